// ----- src/oversampled_uart_tx_rx_top_defines.svh -----
// Assertion macros for the UART block checker.
`ifndef OVERSAMPLED_UART_TX_RX_TOP_DEFINES_SVH
`define OVERSAMPLED_UART_TX_RX_TOP_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define OUART_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define OUART_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/ouart_pkg.sv -----
`timescale 1ns / 1ps

package ouart_pkg;

    typedef struct packed {
        logic       rx_level;
        logic       send_request;
        logic [7:0] send_byte;
    } tick_t;

    typedef struct packed {
        logic       tx_level;
        logic       tx_idle;
        logic       rx_done;
        logic [7:0] rx_byte;
    } result_t;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_START = 2'd1;
    localparam logic [1:0] PH_DATA  = 2'd2;
    localparam logic [1:0] PH_STOP  = 2'd3;

    localparam logic [1:0] STOP_ONE  = 2'd0;
    localparam logic [1:0] STOP_HALF = 2'd1;

    localparam logic [1:0] REG_STOP_LENGTH    = 2'd0;
    localparam logic [1:0] REG_HALF_DUPLEX    = 2'd1;
    localparam logic [1:0] REG_LINE_DIRECTION = 2'd2;

    localparam logic DIR_TX = 1'b0;
    localparam logic DIR_RX = 1'b1;

    localparam logic [3:0] DATA_BITS = 4'd8;

endpackage

// ----- src/oversampled_uart_tx_rx_top.sv -----
`timescale 1ns / 1ps

// 8-bit UART transmitter and receiver fed by oversampling ticks: each tick beat carries
// the sampled receive level and an optional byte to send, and yields one result beat with
// the transmit level, transmitter idle flag, a one-tick done pulse and the receive shift
// register. One tick is taken every clock cycle; all per-tick work is a single pass of
// counter and shift logic into the state and result registers, and a held result stalls
// input only when the output side is not ready. Every bit lasts TICKS_PER_BIT ticks, the
// stop bit 1, 1.5 or 2 bits; the receiver samples data on tick SAMPLE_TICK of each bit.
// Registers (APB, byte address 4*i): 0 stop_length, 1 half_duplex, 2 line_direction
// (0 transmit, 1 receive). Half duplex holds the idle side, but tx still latches a byte.
module oversampled_uart_tx_rx_top
    import ouart_pkg::*;
#(
    parameter int TICKS_PER_BIT = 10,
    parameter int SAMPLE_TICK   = 5
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        tick_valid,
    output logic        tick_ready,
    input  tick_t       tick,
    output logic        result_valid,
    input  logic        result_ready,
    output result_t     result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CNT_W      = $clog2(2 * TICKS_PER_BIT);
    localparam int SAMPLE_LIM = (SAMPLE_TICK > TICKS_PER_BIT) ? TICKS_PER_BIT : SAMPLE_TICK;

    localparam logic [CNT_W:0] BIT_N   = (CNT_W + 1)'(TICKS_PER_BIT);
    localparam logic [CNT_W:0] STOP1_N = (CNT_W + 1)'(TICKS_PER_BIT);
    localparam logic [CNT_W:0] STOP15_N = (CNT_W + 1)'((TICKS_PER_BIT * 3) / 2);
    localparam logic [CNT_W:0] STOP2_N = (CNT_W + 1)'(TICKS_PER_BIT * 2);
    localparam logic [CNT_W:0] SAMPLE_N = (CNT_W + 1)'(SAMPLE_LIM);

    logic [1:0]       stop_length_reg;
    logic             half_duplex_reg;
    logic             line_direction_reg;

    logic [1:0]       tx_phase_reg, tx_phase_next;
    logic [CNT_W-1:0] tx_tick_count_reg, tx_tick_count_next;
    logic [3:0]       tx_bit_count_reg, tx_bit_count_next;
    logic [7:0]       tx_shift_reg, tx_shift_next;
    logic             tx_pending_reg, tx_pending_next;
    logic             tx_finished_reg, tx_finished_next;
    logic             tx_line_reg, tx_line_next;
    logic [1:0]       rx_phase_reg, rx_phase_next;
    logic [CNT_W-1:0] rx_tick_count_reg, rx_tick_count_next;
    logic [3:0]       rx_bit_count_reg, rx_bit_count_next;
    logic [7:0]       rx_shift_reg, rx_shift_next;

    logic             result_valid_reg;
    result_t          result_reg, result_next;

    logic             tick_accept;
    logic             cfg_write;
    logic             tx_run;
    logic             rx_run;
    logic             rx_done;
    logic [CNT_W:0]   tx_n;
    logic [CNT_W:0]   rx_n;
    logic [CNT_W:0]   rx_n_lim;
    logic [CNT_W:0]   stop_n;

    assign tick_ready   = !result_valid_reg || result_ready;
    assign tick_accept  = tick_valid && tick_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_length_reg    <= STOP_ONE;
            half_duplex_reg    <= 1'b0;
            line_direction_reg <= DIR_RX;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_STOP_LENGTH:    stop_length_reg    <= pwdata[1:0];
                REG_HALF_DUPLEX:    half_duplex_reg    <= pwdata[0];
                REG_LINE_DIRECTION: line_direction_reg <= pwdata[0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_STOP_LENGTH:    prdata = {30'd0, stop_length_reg};
            REG_HALF_DUPLEX:    prdata = {31'd0, half_duplex_reg};
            REG_LINE_DIRECTION: prdata = {31'd0, line_direction_reg};
            default:            prdata = 32'd0;
        endcase
    end

    always_comb
    begin
        unique case (stop_length_reg)
            STOP_ONE:  stop_n = STOP1_N;
            STOP_HALF: stop_n = STOP15_N;
            default:   stop_n = STOP2_N;
        endcase
    end

    assign tx_run = !half_duplex_reg || (line_direction_reg == DIR_TX);
    assign rx_run = !half_duplex_reg || (line_direction_reg == DIR_RX);
    assign tx_n   = {1'b0, tx_tick_count_reg} + 1'b1;
    assign rx_n   = {1'b0, rx_tick_count_reg} + 1'b1;
    assign rx_n_lim = (rx_n > SAMPLE_N) ? SAMPLE_N : rx_n;

    // transmitter
    always_comb
    begin
        tx_phase_next      = tx_phase_reg;
        tx_tick_count_next = tx_tick_count_reg;
        tx_bit_count_next  = tx_bit_count_reg;
        tx_shift_next      = tx_shift_reg;
        tx_pending_next    = tx_pending_reg;
        tx_finished_next   = tx_finished_reg;
        tx_line_next       = tx_line_reg;

        if (tick.send_request && tx_finished_reg && (tx_phase_reg == PH_IDLE))
        begin
            tx_finished_next = 1'b0;
            tx_shift_next    = tick.send_byte;
            tx_pending_next  = 1'b1;
        end

        if (tx_run)
        begin
            unique case (tx_phase_reg)
                PH_IDLE:
                begin
                    if (tx_pending_next)
                    begin
                        tx_phase_next      = PH_START;
                        tx_tick_count_next = '0;
                    end
                end
                PH_START:
                begin
                    tx_line_next = 1'b0;
                    if (tx_n >= BIT_N)
                    begin
                        tx_tick_count_next = '0;
                        tx_bit_count_next  = '0;
                        tx_phase_next      = PH_DATA;
                    end
                    else
                    begin
                        tx_tick_count_next = tx_n[CNT_W-1:0];
                    end
                end
                PH_DATA:
                begin
                    tx_line_next = tx_shift_next[0];
                    if (tx_n >= BIT_N)
                    begin
                        tx_tick_count_next = '0;
                        tx_shift_next      = tx_shift_next >> 1;
                        tx_bit_count_next  = tx_bit_count_reg + 4'd1;
                        if (tx_bit_count_next >= DATA_BITS)
                        begin
                            tx_bit_count_next = '0;
                            tx_phase_next     = PH_STOP;
                        end
                    end
                    else
                    begin
                        tx_tick_count_next = tx_n[CNT_W-1:0];
                    end
                end
                default:
                begin
                    tx_line_next = 1'b1;
                    if (tx_n >= stop_n)
                    begin
                        tx_tick_count_next = '0;
                        tx_pending_next    = 1'b0;
                        tx_finished_next   = 1'b1;
                        tx_phase_next      = PH_IDLE;
                    end
                    else
                    begin
                        tx_tick_count_next = tx_n[CNT_W-1:0];
                    end
                end
            endcase
        end
    end

    // receiver
    always_comb
    begin
        rx_phase_next      = rx_phase_reg;
        rx_tick_count_next = rx_tick_count_reg;
        rx_bit_count_next  = rx_bit_count_reg;
        rx_shift_next      = rx_shift_reg;
        rx_done            = 1'b0;

        if (rx_run)
        begin
            unique case (rx_phase_reg)
                PH_IDLE:
                begin
                    if (!tick.rx_level)
                    begin
                        rx_phase_next      = PH_START;
                        rx_tick_count_next = '0;
                    end
                end
                PH_START:
                begin
                    if (rx_n >= BIT_N)
                    begin
                        rx_tick_count_next = '0;
                        rx_bit_count_next  = '0;
                        rx_phase_next      = PH_DATA;
                    end
                    else
                    begin
                        rx_tick_count_next = rx_n[CNT_W-1:0];
                    end
                end
                PH_DATA:
                begin
                    if (rx_n == SAMPLE_N)
                    begin
                        rx_shift_next     = {tick.rx_level, rx_shift_reg[7:1]};
                        rx_bit_count_next = rx_bit_count_reg + 4'd1;
                    end
                    if (rx_n >= BIT_N)
                    begin
                        rx_tick_count_next = '0;
                        if (rx_bit_count_next >= DATA_BITS)
                        begin
                            rx_phase_next = PH_STOP;
                        end
                    end
                    else
                    begin
                        rx_tick_count_next = rx_n[CNT_W-1:0];
                    end
                end
                default:
                begin
                    rx_tick_count_next = rx_n_lim[CNT_W-1:0];
                    if ((rx_n_lim >= SAMPLE_N) && tick.rx_level)
                    begin
                        rx_tick_count_next = '0;
                        rx_phase_next      = PH_IDLE;
                        rx_done            = 1'b1;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        result_next.tx_level = tx_line_next;
        result_next.tx_idle  = tx_finished_next && (tx_phase_next == PH_IDLE);
        result_next.rx_done  = rx_done;
        result_next.rx_byte  = rx_shift_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_phase_reg      <= PH_IDLE;
            tx_tick_count_reg <= '0;
            tx_bit_count_reg  <= '0;
            tx_shift_reg      <= '0;
            tx_pending_reg    <= 1'b0;
            tx_finished_reg   <= 1'b1;
            tx_line_reg       <= 1'b1;
            rx_phase_reg      <= PH_IDLE;
            rx_tick_count_reg <= '0;
            rx_bit_count_reg  <= '0;
            rx_shift_reg      <= '0;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            if (tick_accept)
            begin
                tx_phase_reg      <= tx_phase_next;
                tx_tick_count_reg <= tx_tick_count_next;
                tx_bit_count_reg  <= tx_bit_count_next;
                tx_shift_reg      <= tx_shift_next;
                tx_pending_reg    <= tx_pending_next;
                tx_finished_reg   <= tx_finished_next;
                tx_line_reg       <= tx_line_next;
                rx_phase_reg      <= rx_phase_next;
                rx_tick_count_reg <= rx_tick_count_next;
                rx_bit_count_reg  <= rx_bit_count_next;
                rx_shift_reg      <= rx_shift_next;
                result_valid_reg  <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_accept)
        begin
            result_reg <= result_next;
        end
    end

endmodule

// ----- src/ouart_checker.sv -----
`timescale 1ns / 1ps

`include "oversampled_uart_tx_rx_top_defines.svh"

module ouart_checker
    import ouart_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    tick_ready,
    input logic    result_valid,
    input logic    result_ready,
    input result_t result
);

    // take a tick beat whenever the result register is empty
    `OUART_ASSERT_ALWAYS(a_ready_when_empty, !result_valid |-> tick_ready, "input stalled with no result held")

    // hold a stalled result beat
    `OUART_ASSERT(a_result_hold, result_valid && !result_ready |=> result_valid, "result beat dropped while stalled")
    `OUART_ASSERT(a_result_stable, result_valid && !result_ready |=> $stable(result), "stalled result beat changed")

    // an idle transmitter drives the line high
    `OUART_ASSERT(a_idle_line_high, result_valid && result.tx_idle |-> result.tx_level, "tx line low while transmitter idle")

    // a done pulse never repeats on the next beat
    `OUART_ASSERT(a_done_single, result_valid && result_ready && result.rx_done |=> !(result_valid && result.rx_done), "rx_done on two beats in a row")

endmodule

bind oversampled_uart_tx_rx_top ouart_checker u_ouart_checker (.*);
